[rtl/dpcs_pkg.sv]
// Shared types and constants for the dual pulse channel block.
// No dependencies; imported by dpcs_chan and dual_pulse_channel_with_sweep.
`default_nettype none

package dpcs_pkg;

    localparam int PERIOD_WIDTH = 11;   // timer period width, 11 to 16
    localparam int FIELD_PERIOD_W = 11; // width of the period field on the port
    localparam int MIN_PERIOD = 8;
    localparam int CFG_DATA_W = 8;
    localparam int CFG_INDEX_W = 3;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_SWEEP = 2'd1,
        OP_WRITE = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_DUTY_A  = 3'd0,
        REG_VOLUME_A = 3'd1,
        REG_SWEEP_A = 3'd2,
        REG_DUTY_B  = 3'd3,
        REG_VOLUME_B = 3'd4,
        REG_SWEEP_B = 3'd5,
        REG_ENABLE  = 3'd6,
        REG_SPARE   = 3'd7
    } t_reg_index;

    // Standard 8-step duty patterns, bit n is step n
    localparam logic [7:0] DUTY_TABLE [4] = '{8'h02, 8'h06, 8'h1E, 8'hF9};

    // What one channel does with the transaction now leaving the input register
    typedef struct packed {
        logic                      tick;
        logic                      sweep;
        logic                      write;
        logic [FIELD_PERIOD_W-1:0] new_period;
        logic                      restart;
    } t_chan_cmd;

    typedef struct packed {
        logic [1:0] duty;
        logic [3:0] volume;
        logic [7:0] sweep;     // enable, divider period[3], negate, shift[3]
        logic       enable;
        logic       extra_one; // ones' complement negate (channel A)
    } t_chan_cfg;

endpackage

`default_nettype wire

[rtl/dpcs_chan.sv]
// One pulse channel: period, countdown, duty step and sweep divider state,
// with the next-state update and the level of the updated state. Uses dpcs_pkg.
`default_nettype none

module dpcs_chan (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_advance,
    input  wire dpcs_pkg::t_chan_cmd i_cmd,
    input  wire dpcs_pkg::t_chan_cfg i_cfg,
    output logic [3:0]               o_level_next
);
    import dpcs_pkg::*;

    localparam logic [PERIOD_WIDTH-1:0] MIN_P = PERIOD_WIDTH'(MIN_PERIOD);
    localparam logic [PERIOD_WIDTH-1:0] MAX_P = {PERIOD_WIDTH{1'b1}};

    logic [PERIOD_WIDTH-1:0] r_period, n_period;
    logic [PERIOD_WIDTH-1:0] r_countdown, n_countdown;
    logic [2:0]              r_step, n_step;
    logic [2:0]              r_divider, n_divider;

    logic [PERIOD_WIDTH-1:0] change;
    logic [PERIOD_WIDTH:0]   sum;
    logic [PERIOD_WIDTH:0]   diff;
    logic                    sweep_hit;
    logic [7:0]              pattern;

    always_comb begin
        n_period    = r_period;
        n_countdown = r_countdown;
        n_step      = r_step;
        n_divider   = r_divider;

        change    = r_period >> i_cfg.sweep[2:0];
        sum       = {1'b0, r_period} + {1'b0, change};
        diff      = {1'b0, r_period} - {1'b0, change} - {{PERIOD_WIDTH{1'b0}}, i_cfg.extra_one};
        sweep_hit = (r_divider == 3'd0) && i_cfg.sweep[7] && (r_period > MIN_P);

        if (i_cmd.tick) begin
            if (r_period >= MIN_P && i_cfg.enable) begin
                if (r_countdown != '0) begin
                    n_countdown = r_countdown - 1'b1;
                end else begin
                    n_countdown = r_period;
                    n_step      = r_step + 3'd1;
                end
            end
        end else if (i_cmd.sweep) begin
            if (sweep_hit) begin
                if (!i_cfg.sweep[3]) begin
                    n_period = sum[PERIOD_WIDTH] ? MAX_P : sum[PERIOD_WIDTH-1:0];
                end else begin
                    // borrow out means the result went negative
                    n_period = diff[PERIOD_WIDTH] ? '0 : diff[PERIOD_WIDTH-1:0];
                end
            end
            n_divider = (r_divider == 3'd0) ? i_cfg.sweep[6:4] : r_divider - 3'd1;
        end else if (i_cmd.write) begin
            n_period = PERIOD_WIDTH'(i_cmd.new_period);
            if (i_cmd.restart) begin
                n_step = 3'd0;
            end
        end
    end

    always_comb begin
        pattern = DUTY_TABLE[i_cfg.duty];
        if (n_period < MIN_P) begin
            o_level_next = 4'd0;
        end else begin
            o_level_next = pattern[n_step] ? i_cfg.volume : 4'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period    <= '0;
            r_countdown <= '0;
            r_step      <= '0;
            r_divider   <= '0;
        end else if (i_advance) begin
            r_period    <= n_period;
            r_countdown <= n_countdown;
            r_step      <= n_step;
            r_divider   <= n_divider;
        end
    end

endmodule

`default_nettype wire

[rtl/dual_pulse_channel_with_sweep.sv]
// Two square-wave channels with frequency sweep: one transaction per clock while
// the output is not stalled, the result offered once it passes the input register
// and the channel update into the result register. Throughput is set only by the
// output handshake: the input register refills in the same cycle its transaction moves
// on, so with i_out_ready held high a tick, sweep or period write is taken every clock.
// Configuration registers sit on a plain write port; the user must write them only while idle.
// The block itself does not enforce this. Top level; uses dpcs_pkg and dpcs_chan.
`default_nettype none

module dual_pulse_channel_with_sweep (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_wr_en,
    input  wire logic [dpcs_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  wire logic [dpcs_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_ready,
    input  wire logic [1:0]                           i_operation,
    input  wire logic                                 i_target_channel,
    input  wire logic [dpcs_pkg::FIELD_PERIOD_W-1:0]  i_new_period,
    input  wire logic                                 i_restart_step,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_ready,
    output logic [3:0]                                o_level_a,
    output logic [3:0]                                o_level_b
);
    import dpcs_pkg::*;

    // configuration
    logic [1:0] r_duty_a, r_duty_b;
    logic [3:0] r_volume_a, r_volume_b;
    logic [7:0] r_sweep_a, r_sweep_b;
    logic [1:0] r_enable;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duty_a   <= '0;
            r_volume_a <= '0;
            r_sweep_a  <= '0;
            r_duty_b   <= '0;
            r_volume_b <= '0;
            r_sweep_b  <= '0;
            r_enable   <= '0;
        end else if (i_cfg_wr_en) begin
            case (t_reg_index'(i_cfg_index))
                REG_DUTY_A:   r_duty_a   <= i_cfg_data[1:0];
                REG_VOLUME_A: r_volume_a <= i_cfg_data[3:0];
                REG_SWEEP_A:  r_sweep_a  <= i_cfg_data;
                REG_DUTY_B:   r_duty_b   <= i_cfg_data[1:0];
                REG_VOLUME_B: r_volume_b <= i_cfg_data[3:0];
                REG_SWEEP_B:  r_sweep_b  <= i_cfg_data;
                REG_ENABLE:   r_enable   <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // input register
    logic                      r_in_valid;
    t_op                       r_op;
    logic                      r_target;
    logic [FIELD_PERIOD_W-1:0] r_new_period;
    logic                      r_restart;
    logic                      advance;

    // result register
    logic       r_out_valid;
    logic [3:0] r_level_a, r_level_b;
    logic [3:0] level_a_next, level_b_next;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_op         <= t_op'(i_operation);
            r_target     <= i_target_channel;
            r_new_period <= i_new_period;
            r_restart    <= i_restart_step;
        end
    end

    t_chan_cmd cmd_a, cmd_b;
    t_chan_cfg cfg_a, cfg_b;

    always_comb begin
        cmd_a.tick       = (r_op == OP_TICK);
        cmd_a.sweep      = (r_op == OP_SWEEP);
        cmd_a.write      = (r_op == OP_WRITE) && !r_target;
        cmd_a.new_period = r_new_period;
        cmd_a.restart    = r_restart;
        cmd_b            = cmd_a;
        cmd_b.write      = (r_op == OP_WRITE) && r_target;

        cfg_a = '{duty: r_duty_a, volume: r_volume_a, sweep: r_sweep_a,
                  enable: r_enable[0], extra_one: 1'b1};
        cfg_b = '{duty: r_duty_b, volume: r_volume_b, sweep: r_sweep_b,
                  enable: r_enable[1], extra_one: 1'b0};
    end

    dpcs_chan u_chan_a (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (advance),
        .i_cmd        (cmd_a),
        .i_cfg        (cfg_a),
        .o_level_next (level_a_next)
    );

    dpcs_chan u_chan_b (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (advance),
        .i_cmd        (cmd_b),
        .i_cfg        (cfg_b),
        .o_level_next (level_b_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_level_a <= level_a_next;
            r_level_b <= level_b_next;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_level_a   = r_level_a;
    assign o_level_b   = r_level_b;

    // a held transaction moves to the result register once it is free
    a_advance_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && (!r_out_valid || i_out_ready)) |=> o_out_valid)
        else $error("result register not loaded after advance");

    a_stall_means_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_in_valid && r_out_valid && !i_out_ready))
        else $error("input stalled without a blocked transaction");

    a_level_a_is_volume: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_level_a != 4'd0) |-> (o_level_a == r_volume_a))
        else $error("channel A level differs from its volume");

    a_level_b_is_volume: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_level_b != 4'd0) |-> (o_level_b == r_volume_b))
        else $error("channel B level differs from its volume");

endmodule

`default_nettype wire
